>>> hw/rtl/ordered_array_list_top_macros.svh
// Assertion macros used by the ordered array list top level.
`ifndef ORDERED_ARRAY_LIST_TOP_MACROS_SVH
`define ORDERED_ARRAY_LIST_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define OAL_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Implication whose consequence is checked at the next rising clock edge.
`define OAL_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

// Condition that must hold at every rising clock edge outside reset.
`define OAL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

>>> hw/rtl/oal_pkg.sv
// Shared types and codes of the ordered array list.
`default_nettype none

package oal_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_BADPOS   = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_FIND = 1'b1
	} state_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic               ins_go;
		logic               del_go;
		logic [5:0]         pos;
		logic signed [31:0] value;
	} bcast_t;

	// Width of one group that the find unit examines per cycle.
	localparam int FIND_GROUP = 16;

endpackage

`default_nettype wire

>>> hw/rtl/oal_cell.sv
// One storage cell of the list row: holds one entry and shifts with its neighbors.
`default_nettype none

module oal_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  wire                  clk,
	input  oal_pkg::bcast_t      bcast,
	input  wire [CW-1:0]         count,
	input  wire signed [31:0]    left_data,
	input  wire signed [31:0]    right_data,
	output logic signed [31:0]   data_q,
	output logic                 match
);
	import oal_pkg::*;

	localparam int XW = ((CW > 6) ? CW : 6) + 1;

	logic [XW-1:0] idx_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;

	assign idx_x = XW'(IDX);
	assign pos_x = XW'(bcast.pos);
	assign cnt_x = XW'(count);

	always_ff @(posedge clk) begin
		if (bcast.ins_go) begin
			if (idx_x == pos_x) begin
				data_q <= bcast.value;
			end else if (idx_x > pos_x && idx_x <= cnt_x) begin
				data_q <= left_data;
			end
		end else if (bcast.del_go) begin
			if (idx_x >= pos_x && (idx_x + XW'(1)) < cnt_x) begin
				data_q <= right_data;
			end
		end
	end

	// Only entries below the count take part in a search.
	assign match = (idx_x < cnt_x) && (data_q == bcast.value);

endmodule

`default_nettype wire

>>> hw/rtl/oal_find.sv
// Group-serial priority search over the registered match vector of the cell row.
`default_nettype none

module oal_find #(
	parameter int CAPACITY = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [CAPACITY-1:0]           match_vec,
	output logic                         done,
	output logic                         hit,
	output logic [$clog2(CAPACITY)-1:0]  index
);
	import oal_pkg::*;

	localparam int G    = FIND_GROUP;
	localparam int GW   = $clog2(G);
	localparam int NCH  = (CAPACITY + G - 1) / G;
	localparam int CKW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW = NCH * G;
	localparam int IW   = $clog2(CAPACITY);

	logic [PADW-1:0] vec_q;
	logic [CKW-1:0]  chunk_q;
	logic            busy_q;
	logic [G-1:0]    grp;
	logic [GW-1:0]   pe;
	logic            last;

	assign grp  = vec_q[chunk_q*G +: G];
	assign last = (chunk_q == CKW'(NCH - 1));

	// Lowest set bit of the current group wins.
	always_comb begin
		hit = 1'b0;
		pe  = '0;
		for (int b = G - 1; b >= 0; b--) begin
			if (grp[b]) begin
				hit = 1'b1;
				pe  = GW'(b);
			end
		end
	end

	assign done  = busy_q && (hit || last);
	assign index = IW'({chunk_q, pe});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chunk_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			chunk_q <= '0;
		end else if (done) begin
			busy_q  <= 1'b0;
		end else if (busy_q) begin
			chunk_q <= chunk_q + CKW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q <= PADW'(match_vec);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ordered_array_list_top.sv
// Top level of the ordered array list: command decode, cell row, find unit and result register.
`default_nettype none

// The block keeps an ordered list of up to CAPACITY signed 32-bit values in a row of
// cells, one entry per cell. Each input transaction carries a command in tuser
// (insert, delete, find, clear) and a position and a value in tdata; each command
// produces exactly one result transaction with a status in tuser and the found index
// and the entry count in tdata. Insert, delete and clear are decided and applied in
// the cycle the command is accepted, with every cell shifting toward or away from its
// neighbor at once, so these commands can be accepted in every cycle while results
// are taken. A find compares all entries in parallel in its accept cycle, then the
// find unit walks the match bits sixteen cells per cycle from the low end, and the
// input stays closed until it reaches the group with the first match or the last of
// the ceil(CAPACITY / 16) groups. A find on an empty list is answered in its accept
// cycle. The result register lets the next command be accepted in the cycle the
// previous result is taken. Entry storage is not cleared at reset; only the count is,
// and entries at or above the count are never looked at.

module ordered_array_list_top #(
	parameter int CAPACITY = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [39:0]  s_axis_tdata,   // [5:0] position, [37:6] value, [39:38] zero
	input  wire [1:0]   s_axis_tuser,   // [1:0] cmd
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [4:0] found_index, [10:5] entry_count, [15:11] zero
	output logic [2:0]  m_axis_tuser    // [2:0] status
);
	import oal_pkg::*;

	`include "ordered_array_list_top_macros.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 6) ? CW : 6) + 1;
	localparam int IW = $clog2(CAPACITY);

	// Decoded fields of the incoming transaction.
	op_t                op;
	logic [5:0]         pos;
	logic signed [31:0] value;

	assign op    = op_t'(s_axis_tuser);
	assign pos   = s_axis_tdata[5:0];
	assign value = s_axis_tdata[37:6];

	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	status_t       res_status_q;
	logic [4:0]    res_index_q;
	logic [5:0]    res_count_q;

	logic          in_acc;
	logic          full;
	logic          empty;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          ins_go;
	logic          del_go;
	logic          find_go;
	status_t       imm_status;
	logic          ld_imm;

	logic          f_done;
	logic          f_hit;
	logic [IW-1:0] f_index;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign pos_x  = XW'(pos);
	assign cnt_x  = XW'(count_q);

	// A refused command leaves the list untouched; the full and empty checks take
	// precedence over the position check.
	always_comb begin
		ins_go     = 1'b0;
		del_go     = 1'b0;
		find_go    = 1'b0;
		imm_status = STAT_OK;
		case (op)
			OP_INSERT: begin
				if (full) begin
					imm_status = STAT_FULL;
				end else if (pos_x > cnt_x) begin
					imm_status = STAT_BADPOS;
				end else begin
					ins_go = in_acc;
				end
			end
			OP_DELETE: begin
				if (empty) begin
					imm_status = STAT_EMPTY;
				end else if (pos_x >= cnt_x) begin
					imm_status = STAT_BADPOS;
				end else begin
					del_go = in_acc;
				end
			end
			OP_FIND: begin
				if (empty) begin
					imm_status = STAT_EMPTY;
				end else begin
					find_go = in_acc;
				end
			end
			OP_CLEAR: begin
				imm_status = STAT_OK;
			end
			default: begin
				imm_status = STAT_OK;
			end
		endcase
	end

	// Every command except a find on a non-empty list answers in its accept cycle.
	assign ld_imm = in_acc && !find_go;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (find_go) begin
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				if (f_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output logic: a new command is taken only while no search runs and the result
	// register is free or is being emptied in this cycle.
	always_comb begin
		case (state_q)
			S_IDLE:  s_axis_tready = !out_valid_q || m_axis_tready;
			S_FIND:  s_axis_tready = 1'b0;
			default: s_axis_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_go) begin
				count_q <= count_q + CW'(1);
			end else if (del_go) begin
				count_q <= count_q - CW'(1);
			end else if (in_acc && op == OP_CLEAR) begin
				count_q <= '0;
			end
			if (ld_imm || f_done) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The count reported with a result is the count after the command.
	always_ff @(posedge clk) begin
		if (ld_imm) begin
			res_status_q <= imm_status;
			res_index_q  <= '0;
			if (ins_go) begin
				res_count_q <= 6'(count_q + CW'(1));
			end else if (del_go) begin
				res_count_q <= 6'(count_q - CW'(1));
			end else if (op == OP_CLEAR) begin
				res_count_q <= '0;
			end else begin
				res_count_q <= 6'(count_q);
			end
		end else if (f_done) begin
			res_status_q <= f_hit ? STAT_OK : STAT_NOTFOUND;
			res_index_q  <= f_hit ? 5'(f_index) : 5'd0;
			res_count_q  <= 6'(count_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_status_q;
	assign m_axis_tdata  = {5'd0, res_count_q, res_index_q};

	// Row of cells. Each cell takes its left neighbor on insert and its right
	// neighbor on delete; the ends see zeros, which they never load.
	bcast_t             bcast;
	logic signed [31:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0] match_vec;

	assign bcast.ins_go = ins_go;
	assign bcast.del_go = del_go;
	assign bcast.pos    = pos;
	assign bcast.value  = value;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;

		if (g == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_inner_l
			assign left_d = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner_r
			assign right_d = cell_data[g+1];
		end

		oal_cell #(
			.IDX (g),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.bcast      (bcast),
			.count      (count_q),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (cell_data[g]),
			.match      (match_vec[g])
		);
	end

	oal_find #(
		.CAPACITY (CAPACITY)
	) u_find (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (find_go),
		.match_vec (match_vec),
		.done      (f_done),
		.hit       (f_hit),
		.index     (f_index)
	);

	// The count never runs past the capacity.
	`OAL_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "count exceeds capacity")
	// A search result only appears while the search state is active.
	`OAL_ASSERT_IMPL(a_done_in_find, f_done, state_q == S_FIND, "find done outside search")
	// A result waiting from a search has nowhere to go if the register is still full.
	`OAL_ASSERT_IMPL(a_done_slot_free, f_done, !out_valid_q, "find result overwrites result")
	// An accepted clear leaves an empty list.
	`OAL_ASSERT_NEXT(a_clear_empties, in_acc && op == OP_CLEAR, count_q == '0,
		"clear did not empty the list")

endmodule

`default_nettype wire

>>> verif/ordered_array_list_top_test.sv
// Self-checking testbench for the ordered array list top level.
`timescale 1ns / 100ps

// The testbench streams insert, delete, find and clear commands into the block and
// checks every result transaction against a shadow copy of the list that is kept in a
// small scoreboard class. A short directed part first covers the empty and
// bad-position cases and the extreme values. Random episodes follow. Fill episodes
// insert until the list is full and then push past it. Drain episodes delete until the
// list is empty and then keep going. Churn episodes mix valid commands with noise.
// Finds mostly look for values that are present, so matches at every depth of the row
// occur. Both stream sides idle at random in three phases, the last with no idling.

module ordered_array_list_top_test;
	import oal_pkg::*;

	localparam int LIST_DEPTH = 32;
	localparam int RANDOM_ITEMS_PER_PHASE = 410;
	// A find walks at most two sixteen-entry groups, so this wait covers any tail.
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		status_t    status;
		logic [4:0] found_index;
		logic [5:0] entry_count;
	} list_result_t;

	// Shadow of the list contents and a queue of results still owed by the block.
	class list_shadow;
		logic signed [31:0] entries[LIST_DEPTH];
		int unsigned held;
		list_result_t awaited_results[$];
		int mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		// Applies one accepted command to the shadow and queues the result it owes.
		function void apply_command(op_t op, logic [5:0] pos, logic signed [31:0] val);
			list_result_t res;
			int unsigned p;
			res.status = STAT_OK;
			res.found_index = '0;
			p = 32'(pos);
			case (op)
				OP_INSERT: begin
					// Fullness is judged before the position.
					if (held >= LIST_DEPTH) begin
						res.status = STAT_FULL;
					end else if (p > held) begin
						res.status = STAT_BADPOS;
					end else begin
						for (int i = held; i > p; i--) begin
							entries[5'(i)] = entries[5'(i - 1)];
						end
						entries[5'(p)] = val;
						held++;
					end
				end
				OP_DELETE: begin
					// An empty list is reported before a bad position.
					if (held == 0) begin
						res.status = STAT_EMPTY;
					end else if (p >= held) begin
						res.status = STAT_BADPOS;
					end else begin
						for (int i = p + 1; i < held; i++) begin
							entries[5'(i - 1)] = entries[5'(i)];
						end
						held--;
					end
				end
				OP_FIND: begin
					if (held == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						res.status = STAT_NOTFOUND;
						for (int i = 0; i < held; i++) begin
							if (res.status == STAT_NOTFOUND && entries[5'(i)] == val) begin
								res.status = STAT_OK;
								res.found_index = i[4:0];
							end
						end
					end
				end
				OP_CLEAR: begin
					held = 0;
				end
			endcase
			res.entry_count = held[5:0];
			awaited_results.push_back(res);
		endfunction

		// Compares one result transaction with the oldest awaited result.
		function void check_result(logic [2:0] status, logic [4:0] found_index,
				logic [5:0] entry_count);
			list_result_t want;
			if (awaited_results.size() == 0) begin
				$error("result transaction with no command awaiting it");
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				mismatches++;
			end
			if (found_index !== want.found_index) begin
				$error("found_index: expected %0d, actual %0d", want.found_index,
					found_index);
				mismatches++;
			end
			if (entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", want.entry_count,
					entry_count);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	list_shadow shadow = new();

	// Idle chances in percent per cycle for the sending and the receiving side.
	int unsigned send_idle_pct;
	int unsigned take_idle_pct;
	int unsigned items_sent;

	// A handful of recurring values, extremes among them, so that finds hit duplicates.
	logic signed [31:0] value_pool[8] = '{32'sd0, 32'sd1, -32'sd1, 32'sh8000_0000,
		32'sh7FFF_FFFF, 32'sd5, 32'sd42, -32'sd42};

	ordered_array_list_top #(
		.CAPACITY(LIST_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	// Fixed ceiling on the run; a correct run ends far earlier.
	initial begin
		#20ms;
		$display("ordered_array_list_top_test failed");
		$finish;
	end

	// Value that is either a frequent one or fully random.
	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(1) == 0) begin
			return value_pool[3'($urandom_range(7))];
		end
		return $urandom;
	endfunction

	// Search value that is present in the list most of the time.
	function automatic logic signed [31:0] pick_search_value();
		if (shadow.held != 0 && $urandom_range(3) != 0) begin
			return shadow.entries[5'($urandom_range(shadow.held - 1))];
		end
		return pick_value();
	endfunction

	// Offers one command and returns at the rising edge where it is accepted. The
	// handshake is judged at the falling edge, where both sides are settled.
	task automatic send_command(op_t op, logic [5:0] pos, logic signed [31:0] val);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, val, pos};
		s_axis_tuser <= op;
		@(negedge clk);
		while (!s_axis_tready) begin
			@(negedge clk);
		end
		@(posedge clk);
		shadow.apply_command(op, pos, val);
		items_sent++;
	endtask

	// Inserts at valid positions until the list is full, then pushes past it with
	// positions of every kind.
	task automatic fill_episode();
		while (shadow.held < LIST_DEPTH) begin
			send_command(OP_INSERT, 6'($urandom_range(shadow.held)), pick_value());
			if ($urandom_range(5) == 0) begin
				send_command(OP_FIND, '0, pick_search_value());
			end
		end
		repeat ($urandom_range(1, 3)) begin
			send_command(OP_INSERT, 6'($urandom_range(63)), pick_value());
		end
		send_command(OP_FIND, '0, pick_search_value());
	endtask

	// Deletes at valid positions until the list is empty, then keeps deleting.
	task automatic drain_episode();
		while (shadow.held != 0) begin
			send_command(OP_DELETE, 6'($urandom_range(shadow.held - 1)), '0);
			if ($urandom_range(5) == 0) begin
				send_command(OP_FIND, '0, pick_search_value());
			end
		end
		repeat ($urandom_range(1, 2)) begin
			send_command(OP_DELETE, 6'($urandom_range(63)), pick_value());
		end
		send_command(OP_FIND, '0, pick_value());
	endtask

	// Mostly well-formed commands with some noise, clears included.
	task automatic churn_episode();
		int unsigned roll;
		repeat (20) begin
			roll = $urandom_range(99);
			if (roll < 40) begin
				send_command(OP_INSERT, 6'($urandom_range(shadow.held)), pick_value());
			end else if (roll < 65) begin
				send_command(OP_DELETE,
					(shadow.held == 0) ? 6'd0 : 6'($urandom_range(shadow.held - 1)),
					pick_value());
			end else if (roll < 90) begin
				send_command(OP_FIND, 6'($urandom_range(63)), pick_search_value());
			end else begin
				send_command(op_t'($urandom_range(3)), 6'($urandom_range(63)),
					pick_value());
			end
		end
	endtask

	// The receiver takes or stalls independently in every cycle.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// A result that is valid and taken at a falling edge is accepted at the next
	// rising edge, since nothing changes between the two.
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				shadow.check_result(m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[10:5]);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_INSERT;
		send_idle_pct = 6;
		take_idle_pct = 79;
		items_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the empty list, bad positions, duplicates and extreme values.
		send_command(OP_FIND, '0, 32'sd0);
		send_command(OP_DELETE, 6'd0, 32'sd0);
		send_command(OP_DELETE, 6'd63, -32'sd1);
		send_command(OP_INSERT, 6'd1, 32'sd7);
		send_command(OP_INSERT, 6'd0, 32'sh8000_0000);
		send_command(OP_INSERT, 6'd1, 32'sh7FFF_FFFF);
		send_command(OP_INSERT, 6'd1, 32'sd5);
		send_command(OP_INSERT, 6'd0, 32'sd5);
		send_command(OP_FIND, '0, 32'sd5);
		send_command(OP_FIND, 6'd63, 32'sh7FFF_FFFF);
		send_command(OP_FIND, '0, 32'sh8000_0000);
		send_command(OP_FIND, '0, 32'sd12345);
		send_command(OP_INSERT, 6'd63, 32'sd1);
		send_command(OP_DELETE, 6'd4, 32'sd0);
		send_command(OP_DELETE, 6'd63, 32'sd0);
		send_command(OP_DELETE, 6'd0, 32'sd0);
		send_command(OP_FIND, '0, 32'sd5);
		send_command(OP_DELETE, 6'd2, 32'sd0);
		send_command(OP_INSERT, 6'd3, -32'sd1);
		send_command(OP_CLEAR, 6'd17, 32'sd99);
		send_command(OP_CLEAR, '0, 32'sd0);
		send_command(OP_FIND, '0, 32'sd5);
		send_command(OP_INSERT, 6'd0, -32'sd1);
		send_command(OP_FIND, '0, -32'sd1);

		// Random episodes in three idling phases.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 79 : 0;
			take_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 6 : 0;
			items_sent = 0;
			while (items_sent < RANDOM_ITEMS_PER_PHASE) begin
				case ($urandom_range(3))
					0: fill_episode();
					1: drain_episode();
					default: churn_episode();
				endcase
			end
		end
		s_axis_tvalid <= 1'b0;

		while (shadow.awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0) begin
			$display("ordered_array_list_top_test passed");
		end else begin
			$display("ordered_array_list_top_test failed");
		end
		$finish;
	end

endmodule
